// ----- rtl/w2rgb_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// w2rgb_pkg
// Shared types, wavelength breakpoints, divisors and the gamma table builder.
// ---------------------------------------------------------------------------
package w2rgb_pkg;

  // wavelength in 1/16 nm, and the width of every divider numerator/divisor
  localparam int unsigned WL_W      = 14;
  localparam int unsigned X_W       = 14;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned N_STAGES  = 8;

  // reciprocal divider: numerators stay below 2^DIV_SHIFT
  localparam int unsigned DIV_SHIFT = 14;
  localparam int unsigned RCP_EXTRA = 6;

  localparam logic [CH_W-1:0] IMAX_RESET = 8'd255;

  // segment starts, 1/16 nm
  localparam logic [WL_W-1:0] WL_380 = 14'd6080;
  localparam logic [WL_W-1:0] WL_420 = 14'd6720;
  localparam logic [WL_W-1:0] WL_440 = 14'd7040;
  localparam logic [WL_W-1:0] WL_490 = 14'd7840;
  localparam logic [WL_W-1:0] WL_510 = 14'd8160;
  localparam logic [WL_W-1:0] WL_580 = 14'd9280;
  localparam logic [WL_W-1:0] WL_645 = 14'd10320;
  localparam logic [WL_W-1:0] WL_700 = 14'd11200;
  localparam logic [WL_W-1:0] WL_780 = 14'd12480;
  localparam logic [WL_W-1:0] WL_850 = 14'd13600;

  // divisors (segment lengths, scaled by 10 for the edge factor)
  localparam logic [X_W-1:0] DEN_FAC_UP = 14'd6400;
  localparam logic [X_W-1:0] DEN_FAC_DN = 14'd12800;
  localparam logic [X_W-1:0] DEN_440    = 14'd960;
  localparam logic [X_W-1:0] DEN_490    = 14'd800;
  localparam logic [X_W-1:0] DEN_510    = 14'd320;
  localparam logic [X_W-1:0] DEN_580    = 14'd1120;
  localparam logic [X_W-1:0] DEN_645    = 14'd1040;

  // 0.3 floor of each edge ramp, in the same scaled units
  localparam logic [X_W-1:0] FAC_UP_BASE = 14'd1920;
  localparam logic [X_W-1:0] FAC_DN_BASE = 14'd3840;
  localparam logic [X_W-1:0] FAC_SLOPE   = 14'd7;

  typedef enum logic [1:0] {
    CH_ZERO,
    CH_ONE,
    CH_RATIO
  } ch_sel_e;

  typedef struct packed {
    ch_sel_e red;
    ch_sel_e green;
    ch_sel_e blue;
  } chan_sel_t;

  // largest g in [0, 2^fb] with (g/2^fb)^5 <= (i/dm1)^4, i.e. floor(2^fb * x^0.8)
  function automatic logic [24:0] gamma_entry(int unsigned i, int unsigned dm1,
                                              int unsigned fb);
    logic [191:0] rhs;
    logic [191:0] lhs;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  mid;
    rhs = 192'(i);
    for (int k = 0; k < 3; k++) rhs = rhs * 192'(i);
    rhs = rhs << (5 * fb);
    lo  = 32'd0;
    hi  = 32'd1 << fb;
    mid = 32'd0;
    for (int s = 0; s < 27; s++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 32'd1) >> 1);
        lhs = 192'(mid);
        for (int k = 0; k < 4; k++) lhs = lhs * 192'(mid);
        for (int k = 0; k < 4; k++) lhs = lhs * 192'(dm1);
        if (lhs <= rhs) lo = mid;
        else            hi = mid - 32'd1;
      end
    end
    return lo[24:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/w2rgb_seg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// w2rgb_seg
// Segment decode stage: picks numerators, divisors and reciprocals for the
// edge factor and the one ramping channel, and the mode of each channel.
// ---------------------------------------------------------------------------
module w2rgb_seg import w2rgb_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    en_i,
  input  wire logic [WL_W-1:0]                         wavelength_i,
  output logic      [X_W-1:0]                          fac_x_o,
  output logic      [X_W-1:0]                          fac_den_o,
  output logic      [FRACTION_BITS+RCP_EXTRA-1:0]      fac_rcp_o,
  output logic      [X_W-1:0]                          ch_x_o,
  output logic      [X_W-1:0]                          ch_den_o,
  output logic      [FRACTION_BITS+RCP_EXTRA-1:0]      ch_rcp_o,
  output chan_sel_t                                    sel_o
);

  localparam int unsigned RECIP_W = FRACTION_BITS + RCP_EXTRA;
  localparam logic [63:0] RCP_NUM = 64'd1 << (FRACTION_BITS + DIV_SHIFT);

  localparam logic [RECIP_W-1:0] RCP_FAC_UP = RECIP_W'(RCP_NUM / 64'(DEN_FAC_UP));
  localparam logic [RECIP_W-1:0] RCP_FAC_DN = RECIP_W'(RCP_NUM / 64'(DEN_FAC_DN));
  localparam logic [RECIP_W-1:0] RCP_440    = RECIP_W'(RCP_NUM / 64'(DEN_440));
  localparam logic [RECIP_W-1:0] RCP_490    = RECIP_W'(RCP_NUM / 64'(DEN_490));
  localparam logic [RECIP_W-1:0] RCP_510    = RECIP_W'(RCP_NUM / 64'(DEN_510));
  localparam logic [RECIP_W-1:0] RCP_580    = RECIP_W'(RCP_NUM / 64'(DEN_580));
  localparam logic [RECIP_W-1:0] RCP_645    = RECIP_W'(RCP_NUM / 64'(DEN_645));

  logic [X_W-1:0]     fac_x_d, fac_den_d, ch_x_d, ch_den_d;
  logic [RECIP_W-1:0] fac_rcp_d, ch_rcp_d;
  chan_sel_t          sel_d;

  logic [X_W-1:0]     fac_x_q, fac_den_q, ch_x_q, ch_den_q;
  logic [RECIP_W-1:0] fac_rcp_q, ch_rcp_q;
  chan_sel_t          sel_q;

  always_comb begin
    fac_x_d   = '0;
    fac_den_d = DEN_FAC_UP;
    fac_rcp_d = RCP_FAC_UP;
    ch_x_d    = '0;
    ch_den_d  = DEN_440;
    ch_rcp_d  = RCP_440;
    sel_d     = '{red: CH_ZERO, green: CH_ZERO, blue: CH_ZERO};

    // outside 380..850 nm the factor stays zero, so all channels go black
    if (wavelength_i >= WL_380 && wavelength_i <= WL_850) begin
      if (wavelength_i < WL_420) begin
        fac_x_d = FAC_UP_BASE + (wavelength_i - WL_380) * FAC_SLOPE;
      end else if (wavelength_i <= WL_700) begin
        fac_x_d = DEN_FAC_UP;  // x == divisor gives exactly one
      end else if (wavelength_i <= WL_780) begin
        fac_x_d   = FAC_DN_BASE + (WL_780 - wavelength_i) * FAC_SLOPE;
        fac_den_d = DEN_FAC_DN;
        fac_rcp_d = RCP_FAC_DN;
      end

      if (wavelength_i < WL_440) begin
        ch_x_d = WL_440 - wavelength_i;
        sel_d  = '{red: CH_RATIO, green: CH_ZERO, blue: CH_ONE};
      end else if (wavelength_i < WL_490) begin
        ch_x_d   = wavelength_i - WL_440;
        ch_den_d = DEN_490;
        ch_rcp_d = RCP_490;
        sel_d    = '{red: CH_ZERO, green: CH_RATIO, blue: CH_ONE};
      end else if (wavelength_i < WL_510) begin
        ch_x_d   = WL_510 - wavelength_i;
        ch_den_d = DEN_510;
        ch_rcp_d = RCP_510;
        sel_d    = '{red: CH_ZERO, green: CH_ONE, blue: CH_RATIO};
      end else if (wavelength_i < WL_580) begin
        ch_x_d   = wavelength_i - WL_510;
        ch_den_d = DEN_580;
        ch_rcp_d = RCP_580;
        sel_d    = '{red: CH_RATIO, green: CH_ONE, blue: CH_ZERO};
      end else if (wavelength_i < WL_645) begin
        ch_x_d   = WL_645 - wavelength_i;
        ch_den_d = DEN_645;
        ch_rcp_d = RCP_645;
        sel_d    = '{red: CH_ONE, green: CH_RATIO, blue: CH_ZERO};
      end else begin
        sel_d = '{red: CH_ONE, green: CH_ZERO, blue: CH_ZERO};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fac_x_q   <= fac_x_d;
      fac_den_q <= fac_den_d;
      fac_rcp_q <= fac_rcp_d;
      ch_x_q    <= ch_x_d;
      ch_den_q  <= ch_den_d;
      ch_rcp_q  <= ch_rcp_d;
      sel_q     <= sel_d;
    end
  end

  assign fac_x_o   = fac_x_q;
  assign fac_den_o = fac_den_q;
  assign fac_rcp_o = fac_rcp_q;
  assign ch_x_o    = ch_x_q;
  assign ch_den_o  = ch_den_q;
  assign ch_rcp_o  = ch_rcp_q;
  assign sel_o     = sel_q;

endmodule
`default_nettype wire

// ----- rtl/w2rgb_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// w2rgb_div
// Three-stage constant-divisor ratio: q = floor(x * 2^FB / den), x <= den.
// Reciprocal multiply, back-multiply, then one remainder correction.
// ---------------------------------------------------------------------------
module w2rgb_div import w2rgb_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic [2:0]                          en_i,
  input  wire logic [X_W-1:0]                      x_i,
  input  wire logic [X_W-1:0]                      den_i,
  input  wire logic [FRACTION_BITS+RCP_EXTRA-1:0]  rcp_i,
  output logic      [FRACTION_BITS:0]              q_o
);

  localparam int unsigned RECIP_W = FRACTION_BITS + RCP_EXTRA;
  localparam int unsigned Q_W     = FRACTION_BITS + 1;
  localparam int unsigned PROD_W  = X_W + RECIP_W;
  localparam int unsigned QD_W    = Q_W + X_W;
  localparam int unsigned REM_W   = X_W + FRACTION_BITS + 1;

  logic [PROD_W-1:0] prod_q;
  logic [X_W-1:0]    x_a_q, den_a_q;

  logic [Q_W-1:0]    q0_q;
  logic [QD_W-1:0]   qd_q;
  logic [X_W-1:0]    x_b_q, den_b_q;

  logic [Q_W-1:0]    q0;
  logic [REM_W-1:0]  rem;
  logic [Q_W-1:0]    q_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q  <= PROD_W'(x_i) * PROD_W'(rcp_i);
      x_a_q   <= x_i;
      den_a_q <= den_i;
    end
  end

  // estimate is low by at most one
  assign q0 = prod_q[DIV_SHIFT +: Q_W];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q0_q    <= q0;
      qd_q    <= QD_W'(q0) * QD_W'(den_a_q);
      x_b_q   <= x_a_q;
      den_b_q <= den_a_q;
    end
  end

  assign rem = REM_W'({x_b_q, {FRACTION_BITS{1'b0}}}) - REM_W'(qd_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      q_q <= q0_q + Q_W'(rem >= REM_W'(den_b_q));
    end
  end

  assign q_o = q_q;

endmodule
`default_nettype wire

// ----- rtl/w2rgb_lane.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// w2rgb_lane
// One color channel: channel x factor, table index, gamma ROM lookup and
// full-scale scaling, one register stage each.
// ---------------------------------------------------------------------------
module w2rgb_lane import w2rgb_pkg::*; #(
  parameter int unsigned GAMMA_TABLE_DEPTH = 1024,
  parameter int unsigned FRACTION_BITS     = 16
) (
  input  wire logic                      clk_i,
  input  wire logic [3:0]                en_i,
  input  wire logic [FRACTION_BITS:0]    ch_i,
  input  wire logic [FRACTION_BITS:0]    fac_i,
  input  wire logic [CH_W-1:0]           imax_i,
  output logic      [CH_W-1:0]           val_o
);

  localparam int unsigned EW    = FRACTION_BITS + 1;
  localparam int unsigned IDX_W = $clog2(GAMMA_TABLE_DEPTH);
  localparam int unsigned PI_W  = EW + IDX_W;
  localparam int unsigned SC_W  = EW + CH_W;

  localparam logic [IDX_W-1:0] DM1 = IDX_W'(GAMMA_TABLE_DEPTH - 1);

  typedef logic [EW-1:0] rom_t [GAMMA_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < int'(GAMMA_TABLE_DEPTH); i++) begin
      t[i] = EW'(gamma_entry(i, GAMMA_TABLE_DEPTH - 1, FRACTION_BITS));
    end
    return t;
  endfunction

  localparam rom_t GAMMA_ROM = build_rom();

  logic [2*EW-1:0]  prod;
  logic [PI_W-1:0]  pidx;
  logic [SC_W-1:0]  scaled;

  logic [EW-1:0]    p_q;
  logic [IDX_W-1:0] idx_q;
  logic [EW-1:0]    ent_q;
  logic [CH_W-1:0]  val_q;

  assign prod = (2*EW)'(ch_i) * (2*EW)'(fac_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) p_q <= prod[FRACTION_BITS +: EW];
  end

  // p <= 1.0, so the index never exceeds depth-1
  assign pidx = PI_W'(p_q) * PI_W'(DM1);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) idx_q <= pidx[FRACTION_BITS +: IDX_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) ent_q <= GAMMA_ROM[idx_q];
  end

  assign scaled = SC_W'(ent_q) * SC_W'(imax_i);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) val_q <= scaled[FRACTION_BITS +: CH_W];
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

// ----- rtl/wavelength_to_rgb_core.sv -----
// Throughput: one word per cycle while the output is not stalled; the
// divider, multiplier and ROM stages are all fully pipelined. Each stage has
// its own ready, so bubbles close up and input is taken while a finished
// word waits at the output, as long as some stage is still empty.
// Reset: valid bits clear and intensity_max returns to 255 at once; the gamma
// tables are constant ROMs, so there is no clearing pass.
`default_nettype none
// ---------------------------------------------------------------------------
// wavelength_to_rgb_core
// Wavelength (1/16 nm) to gamma-corrected red/green/blue display bytes.
// ---------------------------------------------------------------------------
module wavelength_to_rgb_core import w2rgb_pkg::*; #(
  parameter int unsigned GAMMA_TABLE_DEPTH = 1024,
  parameter int unsigned FRACTION_BITS     = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CH_W-1:0]  cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WL_W-1:0]  wavelength_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [CH_W-1:0]  blue_o,
  output logic      [CH_W-1:0]  green_o,
  output logic      [CH_W-1:0]  red_o
);

  localparam int unsigned RECIP_W = FRACTION_BITS + RCP_EXTRA;
  localparam int unsigned Q_W     = FRACTION_BITS + 1;
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRACTION_BITS;

  logic [CH_W-1:0]     imax_q;
  logic [N_STAGES-1:0] v_q;
  logic [N_STAGES-1:0] rdy;

  logic [X_W-1:0]      fac_x, fac_den, ch_x, ch_den;
  logic [RECIP_W-1:0]  fac_rcp, ch_rcp;
  chan_sel_t           sel_s1;
  chan_sel_t           sel_s2_q, sel_s3_q, sel_s4_q;

  logic [Q_W-1:0]      fac_q, ratio_q;
  logic [Q_W-1:0]      red_ch, green_ch, blue_ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imax_q <= IMAX_RESET;
    end else if (cfg_we_i) begin
      imax_q <= cfg_data_i;
    end
  end

  // a stage loads when it is empty or its word moves on
  always_comb begin
    rdy[N_STAGES-1] = !v_q[N_STAGES-1] || !out_stall_i;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~rdy) | ({v_q[N_STAGES-2:0], in_valid_i} & rdy);
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[N_STAGES-1];

  w2rgb_seg #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_seg (
    .clk_i       (clk_i),
    .en_i        (rdy[0]),
    .wavelength_i(wavelength_i),
    .fac_x_o     (fac_x),
    .fac_den_o   (fac_den),
    .fac_rcp_o   (fac_rcp),
    .ch_x_o      (ch_x),
    .ch_den_o    (ch_den),
    .ch_rcp_o    (ch_rcp),
    .sel_o       (sel_s1)
  );

  w2rgb_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div_fac (
    .clk_i(clk_i),
    .en_i (rdy[3:1]),
    .x_i  (fac_x),
    .den_i(fac_den),
    .rcp_i(fac_rcp),
    .q_o  (fac_q)
  );

  w2rgb_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div_ch (
    .clk_i(clk_i),
    .en_i (rdy[3:1]),
    .x_i  (ch_x),
    .den_i(ch_den),
    .rcp_i(ch_rcp),
    .q_o  (ratio_q)
  );

  // channel modes ride alongside the dividers
  always_ff @(posedge clk_i) begin
    if (rdy[1]) sel_s2_q <= sel_s1;
    if (rdy[2]) sel_s3_q <= sel_s2_q;
    if (rdy[3]) sel_s4_q <= sel_s3_q;
  end

  function automatic logic [Q_W-1:0] chan_value(ch_sel_e sel, logic [Q_W-1:0] ratio);
    logic [Q_W-1:0] v;
    case (sel)
      CH_ONE:   v = ONE_Q;
      CH_RATIO: v = ratio;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign red_ch   = chan_value(sel_s4_q.red,   ratio_q);
  assign green_ch = chan_value(sel_s4_q.green, ratio_q);
  assign blue_ch  = chan_value(sel_s4_q.blue,  ratio_q);

  w2rgb_lane #(
    .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_lane_red (
    .clk_i (clk_i),
    .en_i  (rdy[7:4]),
    .ch_i  (red_ch),
    .fac_i (fac_q),
    .imax_i(imax_q),
    .val_o (red_o)
  );

  w2rgb_lane #(
    .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_lane_green (
    .clk_i (clk_i),
    .en_i  (rdy[7:4]),
    .ch_i  (green_ch),
    .fac_i (fac_q),
    .imax_i(imax_q),
    .val_o (green_o)
  );

  w2rgb_lane #(
    .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_lane_blue (
    .clk_i (clk_i),
    .en_i  (rdy[7:4]),
    .ch_i  (blue_ch),
    .fac_i (fac_q),
    .imax_i(imax_q),
    .val_o (blue_o)
  );

endmodule
`default_nettype wire

// ----- rtl/w2rgb_chk.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// w2rgb_chk
// Port-level checks for wavelength_to_rgb_core, bound to the top level.
// ---------------------------------------------------------------------------
module w2rgb_chk import w2rgb_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic [WL_W-1:0]  wavelength_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [CH_W-1:0]  blue_o,
  input wire logic [CH_W-1:0]  green_o,
  input wire logic [CH_W-1:0]  red_o
);

  logic       in_acc;
  logic       dark_in;
  logic [6:0] flow_q;  // output not stalled, one bit per past cycle

  assign in_acc  = in_valid_i && !in_stall_o;
  assign dark_in = (wavelength_i < WL_380) || (wavelength_i > WL_850);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q <= '0;
    end else begin
      flow_q <= {flow_q[5:0], !out_stall_i};
    end
  end

  // an empty output register means the whole pipeline can take a word
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register is empty");

  // a word out of the visible band, run through an unstalled pipe, is black
  a_dark_is_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_acc && dark_in, 8) && $past(rst_ni, 8) && (flow_q == 7'h7f))
    |-> (out_valid_o && red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("out-of-band wavelength did not give black after 8 cycles");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(red_o) && $stable(green_o) && $stable(blue_o)))
    else $error("output word changed while stalled");

endmodule

bind wavelength_to_rgb_core w2rgb_chk u_w2rgb_chk (.*);
`default_nettype wire

// ----- tb/wavelength_to_rgb_core_tb.sv -----
// ---------------------------------------------------------------------------
// wavelength_to_rgb_core_tb
// Drives wavelength words through the color mapper under random input gaps
// and output stalls, predicts each RGB word from an exact fixed-point model
// with its own gamma 0.8 table, and compares the results in order.
// ---------------------------------------------------------------------------
module wavelength_to_rgb_core_tb import w2rgb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC       = 16;
  localparam int unsigned LUT_DEPTH  = 1024;
  localparam longint unsigned Q_ONE  = 64'd1 << FRAC;
  localparam int unsigned LATENCY    = 8;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned MAX_CYCLES = 500000;
  localparam int unsigned PHASE_LEN  = 240;

  // breakpoints in 1/16 nm
  localparam longint unsigned NM_380 = 6080;
  localparam longint unsigned NM_420 = 6720;
  localparam longint unsigned NM_440 = 7040;
  localparam longint unsigned NM_490 = 7840;
  localparam longint unsigned NM_510 = 8160;
  localparam longint unsigned NM_580 = 9280;
  localparam longint unsigned NM_645 = 10320;
  localparam longint unsigned NM_700 = 11200;
  localparam longint unsigned NM_780 = 12480;
  localparam longint unsigned NM_850 = 13600;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  class rgb_scoreboard;
    int unsigned     gamma_lut[LUT_DEPTH];
    logic [CH_W-1:0] imax;
    rgb_t            rgb_q[$];
    int unsigned     errors;
    int unsigned     matched;

    function new();
      imax    = 8'd255;
      errors  = 0;
      matched = 0;
      for (int i = 0; i < LUT_DEPTH; i++) gamma_lut[i] = gamma_root(i);
    endfunction

    // true when (g/2^16)^5 > (i/1023)^4, with both sides scaled to integers
    function bit too_big(int unsigned g, logic [159:0] bound);
      logic [159:0] lhs;
      lhs = 160'(g);
      repeat (4) lhs = lhs * 160'(g);
      repeat (4) lhs = lhs * 160'(LUT_DEPTH - 1);
      return lhs > bound;
    endfunction

    // floor(2^16 * x^0.8): start from a float estimate, then settle exactly
    function int unsigned gamma_root(int unsigned i);
      logic [159:0] bound;
      int unsigned  g;
      bound = 160'(i) * 160'(i) * 160'(i) * 160'(i);
      bound = bound << (5 * FRAC);
      g = $rtoi(65536.0 * ((real'(i) / real'(LUT_DEPTH - 1)) ** 0.8));
      if (g > Q_ONE) g = 32'(Q_ONE);
      while (g < Q_ONE && !too_big(g + 1, bound)) g++;
      while (g > 0 && too_big(g, bound)) g--;
      return g;
    endfunction

    function longint unsigned frac_q(longint unsigned num, longint unsigned den);
      return (num << FRAC) / den;
    endfunction

    function logic [CH_W-1:0] shade(longint unsigned ch, longint unsigned fac);
      longint unsigned p;
      longint unsigned idx;
      if (ch == 0) return '0;
      p   = (ch * fac) >> FRAC;
      idx = (p * (LUT_DEPTH - 1)) >> FRAC;
      if (idx > LUT_DEPTH - 1) idx = LUT_DEPTH - 1;
      return CH_W'((longint'(gamma_lut[idx]) * imax) >> FRAC);
    endfunction

    function rgb_t predict(logic [WL_W-1:0] wl);
      longint unsigned w;
      longint unsigned fac;
      longint unsigned r;
      longint unsigned g;
      longint unsigned b;
      rgb_t            res;
      w = wl;
      fac = 0;
      r = 0;
      g = 0;
      b = 0;
      if (w >= NM_380 && w <= NM_850) begin
        if (w < NM_420)       fac = frac_q(1920 + 7 * (w - NM_380), 6400);
        else if (w <= NM_700) fac = Q_ONE;
        else if (w <= NM_780) fac = frac_q(3840 + 7 * (NM_780 - w), 12800);
        if (w < NM_440) begin
          r = frac_q(NM_440 - w, NM_440 - NM_380);
          b = Q_ONE;
        end else if (w < NM_490) begin
          g = frac_q(w - NM_440, NM_490 - NM_440);
          b = Q_ONE;
        end else if (w < NM_510) begin
          g = Q_ONE;
          b = frac_q(NM_510 - w, NM_510 - NM_490);
        end else if (w < NM_580) begin
          r = frac_q(w - NM_510, NM_580 - NM_510);
          g = Q_ONE;
        end else if (w < NM_645) begin
          r = Q_ONE;
          g = frac_q(NM_645 - w, NM_645 - NM_580);
        end else begin
          r = Q_ONE;
        end
      end
      res.blue  = shade(b, fac);
      res.green = shade(g, fac);
      res.red   = shade(r, fac);
      return res;
    endfunction

    function void set_intensity(logic [CH_W-1:0] v);
      imax = v;
    endfunction

    function void note_wavelength(logic [WL_W-1:0] wl);
      rgb_q.insert(rgb_q.size(), predict(wl));
    endfunction

    function void check_result(logic [CH_W-1:0] b, logic [CH_W-1:0] g,
                               logic [CH_W-1:0] r);
      rgb_t exp_rgb;
      if (rgb_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected word b=%0d g=%0d r=%0d", b, g, r);
        return;
      end
      exp_rgb = rgb_q.pop_front();
      if (exp_rgb.blue !== b || exp_rgb.green !== g || exp_rgb.red !== r) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: word %0d expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                   matched + errors, exp_rgb.blue, exp_rgb.green, exp_rgb.red,
                   b, g, r);
      end else begin
        matched++;
      end
    endfunction

    function int unsigned outstanding();
      return rgb_q.size();
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CH_W-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [WL_W-1:0] wavelength_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [CH_W-1:0] blue_o;
  logic [CH_W-1:0] green_o;
  logic [CH_W-1:0] red_o;

  rgb_scoreboard sb;
  bit            tx_gaps = 1'b1;
  bit            rx_gaps = 1'b1;
  bit            hold_req = 1'b0;
  int unsigned   sent = 0;
  int unsigned   settings = 0;
  int unsigned   cycles = 0;

  wavelength_to_rgb_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .wavelength_i(wavelength_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blue_o      (blue_o),
    .green_o     (green_o),
    .red_o       (red_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(blue_o, green_o, red_o);
  end

  // output side: random stall bursts, plus one long hold when requested
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_word(logic [WL_W-1:0] wl);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    wavelength_i <= wl;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_wavelength(wl);
    sent++;
  endtask

  task automatic drop_valid(int unsigned n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic write_intensity(logic [CH_W-1:0] v);
    while (sb.outstanding() != 0) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    sb.set_intensity(v);
    settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly the visible band, some words hugging breakpoints, some anywhere
  function automatic logic [WL_W-1:0] pick_wavelength();
    longint unsigned marks[10];
    int unsigned     sel;
    marks = '{NM_380, NM_420, NM_440, NM_490, NM_510, NM_580, NM_645, NM_700,
              NM_780, NM_850};
    sel = $urandom_range(0, 9);
    if (sel < 6) return WL_W'($urandom_range(NM_380, NM_850));
    if (sel < 8) return WL_W'(marks[$urandom_range(0, 9)] + $urandom_range(0, 80) - 40);
    return WL_W'($urandom_range(0, 16383));
  endfunction

  initial begin
    logic [WL_W-1:0] edge_wl[$];
    logic [CH_W-1:0] levels[$];
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // band edges, segment boundaries and the field extremes at reset scale
    edge_wl = '{14'd0, 14'd16383, 14'd6079, 14'd6080, 14'd6081, 14'd6719, 14'd6720,
                14'd7039, 14'd7040, 14'd7839, 14'd7840, 14'd8159, 14'd8160,
                14'd9279, 14'd9280, 14'd10319, 14'd10320, 14'd11200, 14'd11201,
                14'd12479, 14'd12480, 14'd12481, 14'd13600, 14'd13601, 14'd8191};
    foreach (edge_wl[i]) push_word(edge_wl[i]);
    drop_valid(1);

    levels = '{8'd0, 8'd255, 8'd1, 8'd128, CH_W'($urandom_range(2, 254)), 8'd170,
               8'd255};
    foreach (levels[p]) begin
      write_intensity(levels[p]);
      if (p == levels.size() - 1) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 2 && n == 20) hold_req = 1'b1;
        if (tx_gaps && $urandom_range(0, 5) == 0) drop_valid($urandom_range(1, 16));
        push_word(pick_wavelength());
      end
      drop_valid(1);
    end

    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);

    $display("%0d wavelength words sent, %0d RGB words matched, %0d mismatches",
             sent, sb.matched, sb.errors);
    $display("%0d intensity settings from 0 to 255, with gaps, stalls and a long hold",
             settings);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
